// ===== hw/rtl/sdet_pkg.sv =====
// Shared types and codes for the sorted, de-duplicating event table.
// Request/response payload structs, cell record and flag structs.
// No dependencies.
package sdet_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_READ   = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_RAISED   = 3'd1;
   localparam logic [2:0] ST_KEPT     = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;
   localparam logic [2:0] ST_BADIDX   = 3'd5;
   localparam logic [2:0] ST_CLEARED  = 3'd6;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] event_key;
      logic [31:0] area_code;
      logic [47:0] stamp;
      logic [3:0]  read_index;
   } sdet_request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  position;
      logic [31:0] out_event_key;
      logic [31:0] out_area_code;
      logic [47:0] out_stamp;
      logic [4:0]  fill_level;
   } sdet_response_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] area;
      logic [47:0] stamp;
   } sdet_record_type;

   // per-cell compare results, registered in the evaluate cycle
   typedef struct packed {
      logic match;
      logic place;
      logic older;
   } sdet_cell_flags_type;

   typedef struct packed {
      logic eval;
      logic do_insert;
      logic do_raise;
   } sdet_cell_ctrl_type;

endpackage

// ===== hw/rtl/sdet_cell.sv =====
// One table slot: holds a record, compares it with the pending request and
// shifts in its lower neighbor's record on insert. Depends on sdet_pkg.
module sdet_cell #(
   parameter int CNT_W = 5
) (
   input  logic                          clock,
   input  logic [CNT_W-1:0]              cell_index,
   input  logic [CNT_W-1:0]              count,
   input  sdet_pkg::sdet_cell_ctrl_type  ctrl,
   input  sdet_pkg::sdet_record_type     new_rec,
   input  sdet_pkg::sdet_record_type     prev_rec,
   input  logic                          prev_place,
   output sdet_pkg::sdet_record_type     rec,
   output sdet_pkg::sdet_cell_flags_type flags
);
   import sdet_pkg::*;

   sdet_record_type     rec_ff;
   sdet_record_type     rec_in;
   sdet_cell_flags_type flags_ff;
   sdet_cell_flags_type flags_in;
   logic                valid;

   always_comb begin
      valid          = cell_index < count;
      flags_in.match = valid && (rec_ff.key == new_rec.key);
      flags_in.place = !valid || (rec_ff.key > new_rec.key);
      flags_in.older = rec_ff.stamp < new_rec.stamp;
   end

   always_comb begin
      rec_in = rec_ff;
      if (ctrl.do_insert) begin
         if (flags_ff.place && !prev_place) begin
            rec_in = new_rec;
         end else if (prev_place) begin
            rec_in = prev_rec;
         end
      end
      if (ctrl.do_raise && flags_ff.match && flags_ff.older) begin
         rec_in.stamp = new_rec.stamp;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      if (ctrl.eval) begin
         flags_ff <= flags_in;
      end
   end

   assign rec   = rec_ff;
   assign flags = flags_ff;

endmodule

// ===== hw/rtl/sorted_dedup_event_table_top.sv =====
// Top level of the sorted, de-duplicating event table: a chain of
// sdet_cell slots, the request sequencer and result selection.
// Depends on sdet_pkg and sdet_cell.
//
//   channel   ports                        direction   handshake
//   request   start, busy, req_item        in          start && !busy
//   result    rsp_valid, rsp_item          out         rsp_valid, one cycle
//
// An item passes through three steps: latch, cell compare (flags registered in every
// cell), then apply (cells shift or update, result registered). The result
// strobe shows in the cycle after apply, when the next item may already be
// taken. Reset empties the table at once; stored records are left as they
// are. The receiver cannot stall, so nothing backs up behind a result.
module sorted_dedup_event_table_top #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  sdet_pkg::sdet_request_type req_item,
   output logic                       rsp_valid,
   output sdet_pkg::sdet_response_type rsp_item
);
   import sdet_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EVAL,
      S_APPLY
   } state_type;

   state_type           state_ff;
   sdet_request_type    req_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   sdet_response_type   rsp_ff;
   sdet_response_type   rsp_in;
   logic                rsp_valid_ff;

   sdet_cell_ctrl_type  ctrl;
   sdet_record_type     new_rec;
   sdet_record_type     cell_rec   [TABLE_DEPTH];
   sdet_cell_flags_type cell_flags [TABLE_DEPTH];

   logic                any_match;
   logic                match_older;
   logic [IDX_W-1:0]    match_idx;
   logic [IDX_W-1:0]    ins_idx;
   sdet_record_type     match_rec;
   sdet_record_type     read_rec;
   logic                full;
   logic                read_ok;

   assign new_rec.key   = req_ff.event_key;
   assign new_rec.area  = req_ff.area_code;
   assign new_rec.stamp = req_ff.stamp;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      sdet_cell #(
         .CNT_W(CNT_W)
      ) u_cell (
         .clock      (clock),
         .cell_index (CNT_W'(i)),
         .count      (count_ff),
         .ctrl       (ctrl),
         .new_rec    (new_rec),
         .prev_rec   ((i == 0) ? new_rec : cell_rec[(i == 0) ? 0 : i - 1]),
         .prev_place ((i == 0) ? 1'b0 : cell_flags[(i == 0) ? 0 : i - 1].place),
         .rec        (cell_rec[i]),
         .flags      (cell_flags[i])
      );
   end

   // one-hot selections across the chain
   always_comb begin
      logic prev_p;
      any_match   = 1'b0;
      match_older = 1'b0;
      match_idx   = '0;
      ins_idx     = '0;
      match_rec   = '0;
      read_rec    = '0;
      prev_p      = 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (cell_flags[i].match) begin
            any_match   = 1'b1;
            match_older = match_older | cell_flags[i].older;
            match_idx   = match_idx | IDX_W'(i);
            match_rec   = match_rec | cell_rec[i];
         end
         if (cell_flags[i].place && !prev_p) begin
            ins_idx = ins_idx | IDX_W'(i);
         end
         prev_p = cell_flags[i].place;
         if (32'(i) == 32'(req_ff.read_index)) begin
            read_rec = read_rec | cell_rec[i];
         end
      end
   end

   assign full    = count_ff == CNT_W'(TABLE_DEPTH);
   assign read_ok = 32'(req_ff.read_index) < 32'(count_ff);

   always_comb begin
      ctrl.eval      = state_ff == S_EVAL;
      ctrl.do_insert = 1'b0;
      ctrl.do_raise  = 1'b0;
      count_in       = count_ff;
      rsp_in         = '0;
      rsp_in.status  = ST_BADIDX;
      case (req_ff.req_type)
         REQ_INSERT: begin
            if (any_match) begin
               ctrl.do_raise        = state_ff == S_APPLY;
               rsp_in.status        = match_older ? ST_RAISED : ST_KEPT;
               rsp_in.position      = 4'(match_idx);
               rsp_in.out_event_key = match_rec.key;
               rsp_in.out_area_code = match_rec.area;
               rsp_in.out_stamp     = match_older ? req_ff.stamp : match_rec.stamp;
            end else if (full) begin
               rsp_in.status = ST_FULL;
            end else begin
               ctrl.do_insert       = state_ff == S_APPLY;
               count_in             = count_ff + CNT_W'(1);
               rsp_in.status        = ST_INSERTED;
               rsp_in.position      = 4'(ins_idx);
               rsp_in.out_event_key = req_ff.event_key;
               rsp_in.out_area_code = req_ff.area_code;
               rsp_in.out_stamp     = req_ff.stamp;
            end
         end
         REQ_READ: begin
            if (read_ok) begin
               rsp_in.status        = ST_READ;
               rsp_in.position      = req_ff.read_index;
               rsp_in.out_event_key = read_rec.key;
               rsp_in.out_area_code = read_rec.area;
               rsp_in.out_stamp     = read_rec.stamp;
            end
         end
         REQ_CLEAR: begin
            count_in      = '0;
            rsp_in.status = ST_CLEARED;
         end
         default: begin
            rsp_in.status = ST_BADIDX;
         end
      endcase
      rsp_in.fill_level = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= state_ff == S_APPLY;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff   <= req_item;
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               count_ff     <= count_in;
               rsp_ff       <= rsp_in;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_apply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == S_APPLY))
      else $error("result strobe without apply cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(TABLE_DEPTH))
      else $error("fill count above table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == ST_INSERTED)
         |-> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("insert did not grow fill count by one");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_EVAL))
      else $error("accepted transfer did not start evaluation");
`endif

endmodule

// ===== tb/sv/tb_sorted_dedup_event_table_top.sv =====
// Testbench for sorted_dedup_event_table_top: a directed table, then random episodes,
// each result checked against its listed response or a local model of the sorted table.
// Depends on sdet_pkg and the sorted_dedup_event_table_top RTL.
module tb_sorted_dedup_event_table_top;
   import sdet_pkg::*;

   localparam int DEPTH = 16;
   localparam int RANDOM_ITEMS = 600;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef enum int {EP_FILL, EP_MIXED, EP_NOISE} episode_kind_type;

   typedef struct {
      sdet_request_type  req;
      bit                typed;
      sdet_response_type rsp;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   sdet_request_type  req_item;
   logic              rsp_valid;
   sdet_response_type rsp_item;

   logic [31:0] tbl_keys   [DEPTH];
   logic [31:0] tbl_areas  [DEPTH];
   logic [47:0] tbl_stamps [DEPTH];
   logic [4:0]  tbl_count;

   logic [31:0]       key_pool [8];
   sdet_response_type expected_q [$];
   stim_row_type      directed_rows [$];
   int                mismatch_count = 0;
   int                burst_left = 0;

   sorted_dedup_event_table_top #(.TABLE_DEPTH(DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic sdet_request_type make_req(input logic [1:0] kind,
         input logic [31:0] key, input logic [31:0] area, input logic [47:0] stamp,
         input logic [3:0] idx);
      sdet_request_type r;
      r.req_type   = kind;
      r.event_key  = key;
      r.area_code  = area;
      r.stamp      = stamp;
      r.read_index = idx;
      return r;
   endfunction

   function automatic sdet_response_type make_rsp(input logic [2:0] st,
         input logic [3:0] pos, input logic [31:0] key, input logic [31:0] area,
         input logic [47:0] stamp, input logic [4:0] fill);
      sdet_response_type r;
      r.status        = st;
      r.position      = pos;
      r.out_event_key = key;
      r.out_area_code = area;
      r.out_stamp     = stamp;
      r.fill_level    = fill;
      return r;
   endfunction

   // updates the local table and returns the response the block should give
   function automatic sdet_response_type apply_to_table(input sdet_request_type r);
      sdet_response_type rsp;
      logic [2:0]        st;
      int                i;
      int                pos;
      bit                hit;
      rsp = make_rsp(ST_BADIDX, 4'd0, 32'd0, 32'd0, 48'd0, tbl_count);
      hit = 1'b0;
      case (r.req_type)
         REQ_INSERT: begin
            for (i = 0; i < int'(tbl_count); i++) begin
               if (!hit && tbl_keys[i] == r.event_key) begin
                  hit = 1'b1;
                  if (tbl_stamps[i] < r.stamp) begin
                     tbl_stamps[i] = r.stamp;
                     st = ST_RAISED;
                  end else begin
                     st = ST_KEPT;
                  end
                  rsp = make_rsp(st, 4'(i), tbl_keys[i], tbl_areas[i], tbl_stamps[i],
                                 tbl_count);
               end
            end
            if (!hit) begin
               if (int'(tbl_count) >= DEPTH) begin
                  rsp = make_rsp(ST_FULL, 4'd0, 32'd0, 32'd0, 48'd0, tbl_count);
               end else begin
                  pos = int'(tbl_count);
                  while (pos > 0 && tbl_keys[pos-1] > r.event_key) begin
                     tbl_keys[pos]   = tbl_keys[pos-1];
                     tbl_areas[pos]  = tbl_areas[pos-1];
                     tbl_stamps[pos] = tbl_stamps[pos-1];
                     pos--;
                  end
                  tbl_keys[pos]   = r.event_key;
                  tbl_areas[pos]  = r.area_code;
                  tbl_stamps[pos] = r.stamp;
                  tbl_count = tbl_count + 5'd1;
                  rsp = make_rsp(ST_INSERTED, 4'(pos), r.event_key, r.area_code, r.stamp,
                                 tbl_count);
               end
            end
         end
         REQ_READ: begin
            if (5'(r.read_index) < tbl_count) begin
               rsp = make_rsp(ST_READ, r.read_index, tbl_keys[r.read_index],
                              tbl_areas[r.read_index], tbl_stamps[r.read_index], tbl_count);
            end
         end
         REQ_CLEAR: begin
            tbl_count = 5'd0;
            rsp = make_rsp(ST_CLEARED, 4'd0, 32'd0, 32'd0, 48'd0, tbl_count);
         end
         default: ;
      endcase
      return rsp;
   endfunction

   function automatic sdet_request_type rand_request(input episode_kind_type kind);
      sdet_request_type r;
      int               pick;
      r.req_type   = 2'($urandom_range(0, 3));
      r.event_key  = $urandom;
      r.area_code  = $urandom;
      r.stamp      = {16'($urandom), $urandom};
      r.read_index = 4'($urandom_range(0, 15));
      if (kind == EP_NOISE) return r;
      case ($urandom_range(0, 9))
         0:       r.stamp = '0;
         1:       r.stamp = '1;
         2, 3, 4: r.stamp = 48'($urandom_range(0, 31));
         default: ;
      endcase
      pick = $urandom_range(0, 99);
      if (kind == EP_FILL) begin
         r.req_type = REQ_INSERT;
         if (pick < 20 && tbl_count != 0)
            r.event_key = tbl_keys[$urandom_range(0, int'(tbl_count) - 1)];
      end else begin
         if (pick < 30 && tbl_count != 0)
            r.event_key = tbl_keys[$urandom_range(0, int'(tbl_count) - 1)];
         else if (pick < 80)
            r.event_key = key_pool[$urandom_range(0, 7)];
         pick = $urandom_range(0, 99);
         if (pick < 55)
            r.req_type = REQ_INSERT;
         else if (pick < 90)
            r.req_type = REQ_READ;
         else if (pick < 95)
            r.req_type = REQ_CLEAR;
         else
            r.req_type = REQ_UNUSED;
         if (r.req_type == REQ_READ && tbl_count != 0 && $urandom_range(0, 9) < 7)
            r.read_index = 4'($urandom_range(0, int'(tbl_count) - 1));
      end
      return r;
   endfunction

   task automatic add_row(input sdet_request_type req, input bit typed,
         input sdet_response_type rsp);
      stim_row_type row;
      row.req   = req;
      row.typed = typed;
      row.rsp   = rsp;
      directed_rows.push_back(row);
   endtask

   // one transfer; the sender may idle between bursts of random length
   task automatic issue(input sdet_request_type item, input bit typed,
         input sdet_response_type typed_rsp);
      sdet_response_type predicted;
      int                gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start    <= 1'b0;
            req_item <= rand_request(EP_NOISE);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      start    <= 1'b1;
      req_item <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_to_table(item);
      expected_q.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic check_field(input string name, input logic [47:0] want,
         input logic [47:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      sdet_response_type want;
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatch_count++;
         end else begin
            want = expected_q.pop_front();
            check_field("status", want.status, rsp_item.status);
            check_field("position", want.position, rsp_item.position);
            check_field("out_event_key", want.out_event_key, rsp_item.out_event_key);
            check_field("out_area_code", want.out_area_code, rsp_item.out_area_code);
            check_field("out_stamp", want.out_stamp, rsp_item.out_stamp);
            check_field("fill_level", want.fill_level, rsp_item.fill_level);
         end
      end
   end

   initial begin
      int               i;
      int               len;
      int               sent;
      int               wait_cycles;
      episode_kind_type kind;
      sdet_response_type none;
      none = '0;
      tbl_count = 5'd0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_item <= '0;

      add_row(make_req(REQ_READ, 32'd0, 32'd0, 48'd0, 4'd0), 1'b1,
              make_rsp(ST_BADIDX, 4'd0, 32'd0, 32'd0, 48'd0, 5'd0));
      add_row(make_req(REQ_READ, '1, '1, '1, 4'hF), 1'b1,
              make_rsp(ST_BADIDX, 4'd0, 32'd0, 32'd0, 48'd0, 5'd0));
      add_row(make_req(REQ_UNUSED, '1, '1, '1, 4'hF), 1'b1,
              make_rsp(ST_BADIDX, 4'd0, 32'd0, 32'd0, 48'd0, 5'd0));
      add_row(make_req(REQ_INSERT, 32'h8000_0000, '1, '1, 4'd0), 1'b1,
              make_rsp(ST_INSERTED, 4'd0, 32'h8000_0000, '1, '1, 5'd1));
      add_row(make_req(REQ_INSERT, 32'd0, 32'd0, 48'd0, 4'hF), 1'b0, none);
      add_row(make_req(REQ_INSERT, '1, 32'h1234_5678, 48'd1, 4'd0), 1'b0, none);
      // same key again: stamp not newer, area ignored
      add_row(make_req(REQ_INSERT, 32'h8000_0000, 32'd0, 48'd0, 4'd0), 1'b0, none);
      add_row(make_req(REQ_INSERT, 32'd0, '1, 48'h1000, 4'd0), 1'b0, none);
      add_row(make_req(REQ_INSERT, 32'd0, 32'd0, 48'h1000, 4'd0), 1'b0, none);
      add_row(make_req(REQ_INSERT, '1, 32'd0, '1, 4'd0), 1'b0, none);
      add_row(make_req(REQ_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 48'h5A5A_5A5A_5A5A, 4'd0),
              1'b0, none);
      for (i = 0; i < 5; i++)
         add_row(make_req(REQ_READ, 32'd0, 32'd0, 48'd0, 4'(i)), 1'b0, none);
      add_row(make_req(REQ_READ, 32'd0, 32'd0, 48'd0, 4'hF), 1'b0, none);
      add_row(make_req(REQ_CLEAR, '1, '1, '1, 4'hF), 1'b1,
              make_rsp(ST_CLEARED, 4'd0, 32'd0, 32'd0, 48'd0, 5'd0));
      add_row(make_req(REQ_READ, 32'd0, 32'd0, 48'd0, 4'd0), 1'b1,
              make_rsp(ST_BADIDX, 4'd0, 32'd0, 32'd0, 48'd0, 5'd0));
      add_row(make_req(REQ_INSERT, 32'd1, 32'd2, 48'd3, 4'd0), 1'b1,
              make_rsp(ST_INSERTED, 4'd0, 32'd1, 32'd2, 48'd3, 5'd1));
      add_row(make_req(REQ_INSERT, 32'd1, 32'd9, 48'd2, 4'd0), 1'b0, none);
      add_row(make_req(REQ_CLEAR, 32'd0, 32'd0, 48'd0, 4'd0), 1'b1,
              make_rsp(ST_CLEARED, 4'd0, 32'd0, 32'd0, 48'd0, 5'd0));

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n])
         issue(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].rsp);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 19))
            0, 1, 2:          kind = EP_NOISE;
            3, 4, 5, 6, 7, 8: kind = EP_FILL;
            default:          kind = EP_MIXED;
         endcase
         for (i = 0; i < 8; i++)
            key_pool[i] = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 63));
         if ($urandom_range(0, 1) == 0) key_pool[0] = '0;
         if ($urandom_range(0, 1) == 0) key_pool[7] = '1;
         case (kind)
            EP_FILL:  len = $urandom_range(18, 26);
            EP_NOISE: len = $urandom_range(5, 10);
            default:  len = $urandom_range(10, 40);
         endcase
         repeat (len) begin
            issue(rand_request(kind), 1'b0, none);
            sent++;
         end
      end
      start <= 1'b0;

      wait_cycles = 0;
      while (expected_q.size() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (expected_q.size() != 0) begin
         $error("%0d expected results never arrived", expected_q.size());
         mismatch_count += expected_q.size();
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
